// File: rtl/core/afvsp_pkg.sv
// shared types, constants and tables for the four-voice adpcm sample player
package afvsp_pkg;

    localparam int ROM_BYTES   = 131072;
    localparam int ROM_AW      = $clog2(ROM_BYTES);
    localparam int VOICE_COUNT = 4;
    localparam int VOICE_W     = $clog2(VOICE_COUNT);
    localparam int HDR_BYTES   = 6;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    localparam logic signed [15:0] MIX_LIMIT = 16'sd1200;
    localparam logic [12:0]        PHASE_ONE = 13'd4096;
    localparam logic [11:0]        PHASE_STEP_RESET = 12'd969;
    localparam logic [5:0]         STEP_INDEX_MAX = 6'd48;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_CMD  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_START,
        ST_RD,
        ST_DEC,
        ST_MUL,
        ST_VOL,
        ST_ACC,
        ST_FILT,
        ST_MIX
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_HDR,
        DP_START,
        DP_RD,
        DP_DEC,
        DP_MUL,
        DP_VOL,
        DP_ACC,
        DP_FILT,
        DP_MIX
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic [VOICE_W-1:0] voice;
        logic [2:0]         hdr_idx;
    } t_dp_ctl;

    typedef struct packed {
        logic pending;
        logic out_busy;
    } t_dp_sts;

    function automatic logic [10:0] step_size(input logic [5:0] idx);
        logic [10:0] v;
        unique case (idx)
            6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;
            6'd3:  v = 11'd21;   6'd4:  v = 11'd23;   6'd5:  v = 11'd25;
            6'd6:  v = 11'd28;   6'd7:  v = 11'd31;   6'd8:  v = 11'd34;
            6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
            6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;
            6'd15: v = 11'd66;   6'd16: v = 11'd73;   6'd17: v = 11'd80;
            6'd18: v = 11'd88;   6'd19: v = 11'd97;   6'd20: v = 11'd107;
            6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
            6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;
            6'd27: v = 11'd209;  6'd28: v = 11'd230;  6'd29: v = 11'd253;
            6'd30: v = 11'd279;  6'd31: v = 11'd307;  6'd32: v = 11'd337;
            6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
            6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;
            6'd39: v = 11'd658;  6'd40: v = 11'd724;  6'd41: v = 11'd796;
            6'd42: v = 11'd876;  6'd43: v = 11'd963;  6'd44: v = 11'd1060;
            6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
            6'd48: v = 11'd1552;
            default: v = 11'd16;
        endcase
        return v;
    endfunction

    function automatic logic signed [6:0] index_shift(input logic [2:0] code);
        logic signed [6:0] v;
        case (code)
            3'd4:    v = 7'sd2;
            3'd5:    v = 7'sd4;
            3'd6:    v = 7'sd6;
            3'd7:    v = 7'sd8;
            default: v = -7'sd1;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] volume_code(input logic [3:0] code);
        logic [5:0] v;
        case (code)
            4'd0:    v = 6'd32;
            4'd1:    v = 6'd22;
            4'd2:    v = 6'd16;
            4'd3:    v = 6'd11;
            4'd4:    v = 6'd8;
            4'd5:    v = 6'd6;
            4'd6:    v = 6'd4;
            4'd7:    v = 6'd3;
            4'd8:    v = 6'd2;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/afvsp_ctrl.sv
// sequencing state machine: header fetch and per-voice tick schedule
module afvsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_opcode,
    input  afvsp_pkg::t_dp_sts  i_sts,
    output logic                o_in_ready,
    output afvsp_pkg::t_dp_ctl  o_ctl
);
    import afvsp_pkg::*;

    t_state               r_state, n_state;
    logic [VOICE_W-1:0]   r_voice, n_voice;
    logic [2:0]           r_hdr, n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_voice <= '0;
            r_hdr   <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_hdr   <= n_hdr;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_hdr   = r_hdr;
        unique case (r_state)
            ST_IDLE: begin
                n_voice = '0;
                n_hdr   = '0;
                if (i_in_valid) begin
                    if (t_opcode'(i_opcode) == OP_TICK) begin
                        n_state = ST_RD;
                    end else if (t_opcode'(i_opcode) == OP_CMD && i_sts.pending) begin
                        n_state = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                n_hdr = r_hdr + 3'd1;
                if (r_hdr == 3'(HDR_BYTES)) begin
                    n_state = ST_START;
                end
            end
            ST_START: n_state = ST_IDLE;
            ST_RD:    n_state = ST_DEC;
            ST_DEC:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_VOL;
            ST_VOL:   n_state = ST_ACC;
            ST_ACC: begin
                if (r_voice == VOICE_W'(VOICE_COUNT - 1)) begin
                    n_state = ST_FILT;
                end else begin
                    n_voice = r_voice + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_FILT:  n_state = ST_MIX;
            ST_MIX: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_ctl.op      = DP_NONE;
        o_ctl.voice   = r_voice;
        o_ctl.hdr_idx = r_hdr;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = DP_ACCEPT;
            end
            ST_HDR:   o_ctl.op = DP_HDR;
            ST_START: o_ctl.op = DP_START;
            ST_RD:    o_ctl.op = DP_RD;
            ST_DEC:   o_ctl.op = DP_DEC;
            ST_MUL:   o_ctl.op = DP_MUL;
            ST_VOL:   o_ctl.op = DP_VOL;
            ST_ACC:   o_ctl.op = DP_ACC;
            ST_FILT:  o_ctl.op = DP_FILT;
            ST_MIX: begin
                if (!i_sts.out_busy) o_ctl.op = DP_MIX;
            end
            default:  o_ctl.op = DP_NONE;
        endcase
    end

endmodule

// File: rtl/core/afvsp_dp.sv
// datapath: sample rom, voice state, adpcm decode, mixer and output register
module afvsp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afvsp_pkg::t_dp_ctl  i_ctl,
    input  logic [1:0]          i_opcode,
    input  logic                i_bank,
    input  logic [16:0]         i_rom_address,
    input  logic [7:0]          i_data_byte,
    input  logic signed [15:0]  i_fm_sample,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_out_ready,
    output afvsp_pkg::t_dp_sts  o_sts,
    output logic                o_out_valid,
    output logic signed [11:0]  o_audio,
    output logic                o_clipped
);
    import afvsp_pkg::*;

    logic [7:0]         r_rom [ROM_BYTES];
    logic [7:0]         r_rom_q;
    logic [ROM_AW-1:0]  w_rd_addr;

    logic [11:0]        r_phase_step;
    logic [12:0]        r_phase;
    logic               r_dec;
    logic               r_pending;
    logic [6:0]         r_sample;
    logic [7:0]         r_cmd;
    logic               r_bank;
    logic [47:0]        r_hdr;
    logic signed [15:0] r_fm;

    logic [VOICE_COUNT-1:0] r_playing;
    logic [18:0]        r_base  [VOICE_COUNT];
    logic [19:0]        r_idx   [VOICE_COUNT];
    logic [19:0]        r_cnt   [VOICE_COUNT];
    logic signed [11:0] r_sig   [VOICE_COUNT];
    logic signed [11:0] r_prev  [VOICE_COUNT];
    logic [5:0]         r_step  [VOICE_COUNT];
    logic [5:0]         r_vol   [VOICE_COUNT];

    logic signed [25:0] r_prod;
    logic signed [20:0] r_vp;
    logic signed [20:0] r_acc;
    logic signed [19:0] r_lp;

    logic               r_out_valid;
    logic signed [11:0] r_audio;
    logic               r_clipped;

    logic [VOICE_W-1:0] v;
    logic [12:0]        w_phase_sum;
    logic [3:0]         w_nib;
    logic [10:0]        w_sv;
    logic [11:0]        w_d;
    logic signed [13:0] w_s;
    logic signed [11:0] w_s_clamp;
    logic signed [6:0]  w_st;
    logic [5:0]         w_st_clamp;
    logic [19:0]        w_idx_next;
    logic [17:0]        w_start, w_stop;
    logic signed [13:0] w_interp;
    logic signed [18:0] w_raw;
    logic signed [21:0] w_diff;
    logic signed [23:0] w_lp_step;
    logic signed [14:0] w_mix_sum;
    logic signed [15:0] w_mix;

    assign v = i_ctl.voice;

    // rom read address: header bytes or the current voice's byte
    always_comb begin
        if (i_ctl.op == DP_HDR) begin
            w_rd_addr = {r_bank, 6'd0, r_sample, i_ctl.hdr_idx};
        end else begin
            w_rd_addr = r_base[v][ROM_AW-1:0] + r_idx[v][ROM_AW:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == DP_ACCEPT && t_opcode'(i_opcode) == OP_LOAD) begin
            r_rom[i_rom_address] <= i_data_byte;
        end
        r_rom_q <= r_rom[w_rd_addr];
    end

    // adpcm nibble decode
    always_comb begin
        w_nib = r_idx[v][0] ? r_rom_q[3:0] : r_rom_q[7:4];
        w_sv  = step_size(r_step[v]);
        w_d   = 12'(w_sv >> 3)
              + (w_nib[2] ? 12'(w_sv) : 12'd0)
              + (w_nib[1] ? 12'(w_sv >> 1) : 12'd0)
              + (w_nib[0] ? 12'(w_sv >> 2) : 12'd0);
        w_s = 14'(r_sig[v]) + (w_nib[3] ? -$signed({2'b00, w_d}) : $signed({2'b00, w_d}));
        if (w_s > 14'sd2047) begin
            w_s_clamp = 12'sd2047;
        end else if (w_s < -14'sd2048) begin
            w_s_clamp = -12'sd2048;
        end else begin
            w_s_clamp = w_s[11:0];
        end
        w_st = $signed({1'b0, r_step[v]}) + index_shift(w_nib[2:0]);
        if (w_st < 7'sd0) begin
            w_st_clamp = 6'd0;
        end else if (w_st > $signed({1'b0, STEP_INDEX_MAX})) begin
            w_st_clamp = STEP_INDEX_MAX;
        end else begin
            w_st_clamp = w_st[5:0];
        end
        w_idx_next = r_idx[v] + 20'd1;
    end

    always_comb begin
        w_phase_sum = r_phase + {1'b0, r_phase_step};
        w_start     = r_hdr[41:24];
        w_stop      = r_hdr[17:0];
        w_interp    = 14'(r_prev[v]) + 14'(r_prod >>> 12);
        w_raw       = 19'(r_acc >>> 2);
        w_diff      = 22'(w_raw) - 22'(r_lp);
        w_lp_step   = (24'(w_diff) <<< 1) + 24'(w_diff);
        w_mix_sum   = 15'(r_lp >>> 6) + 15'(r_fm >>> 4);
        w_mix       = 16'(w_mix_sum) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RESET;
            r_phase      <= '0;
            r_dec        <= 1'b0;
            r_pending    <= 1'b0;
            r_playing    <= '0;
            r_lp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_phase_step <= i_cfg_wdata;
            if (r_out_valid && i_out_ready && i_ctl.op != DP_MIX) r_out_valid <= 1'b0;
            case (i_ctl.op)
                DP_ACCEPT: begin
                    r_cmd  <= i_data_byte;
                    r_bank <= i_bank;
                    r_fm   <= i_fm_sample;
                    r_acc  <= '0;
                    if (t_opcode'(i_opcode) == OP_TICK) begin
                        if (w_phase_sum >= PHASE_ONE) begin
                            r_phase <= w_phase_sum - PHASE_ONE;
                            r_dec   <= 1'b1;
                        end else begin
                            r_phase <= w_phase_sum;
                            r_dec   <= 1'b0;
                        end
                    end else if (t_opcode'(i_opcode) == OP_CMD && !r_pending) begin
                        if (i_data_byte[7]) begin
                            r_pending <= 1'b1;
                            r_sample  <= i_data_byte[6:0];
                        end else begin
                            for (int i = 0; i < VOICE_COUNT; i++) begin
                                if (i_data_byte[3+i]) r_playing[i] <= 1'b0;
                            end
                        end
                    end
                end
                DP_HDR: begin
                    if (i_ctl.hdr_idx != 3'd0) r_hdr <= {r_hdr[39:0], r_rom_q};
                end
                DP_START: begin
                    r_pending <= 1'b0;
                    for (int i = 0; i < VOICE_COUNT; i++) begin
                        if (r_cmd[4+i] && !r_playing[i] && w_start < w_stop) begin
                            r_playing[i] <= 1'b1;
                            r_base[i]    <= {2'b00, r_bank, 16'd0} + {1'b0, w_start};
                            r_idx[i]     <= '0;
                            r_cnt[i]     <= {19'({1'b0, w_stop} - {1'b0, w_start} + 19'd1),
                                             1'b0};
                            r_sig[i]     <= '0;
                            r_prev[i]    <= '0;
                            r_step[i]    <= '0;
                            r_vol[i]     <= volume_code(r_cmd[3:0]);
                        end
                    end
                end
                DP_DEC: begin
                    if (r_dec && r_playing[v]) begin
                        r_prev[v] <= r_sig[v];
                        r_sig[v]  <= w_s_clamp;
                        r_step[v] <= w_st_clamp;
                        r_idx[v]  <= w_idx_next;
                        if (w_idx_next >= r_cnt[v]) r_playing[v] <= 1'b0;
                    end
                end
                DP_MUL: begin
                    r_prod <= 26'(13'(r_sig[v]) - 13'(r_prev[v]))
                            * $signed({14'd0, r_phase[11:0]});
                end
                DP_VOL: begin
                    r_vp <= 21'(w_interp) * $signed({15'd0, r_vol[v]});
                end
                DP_ACC: begin
                    if (r_playing[v]) r_acc <= r_acc + r_vp;
                end
                DP_FILT: begin
                    r_lp <= r_lp + 20'(w_lp_step >>> 2);
                end
                DP_MIX: begin
                    r_out_valid <= 1'b1;
                    if (w_mix > MIX_LIMIT) begin
                        r_audio   <= 12'(MIX_LIMIT);
                        r_clipped <= 1'b1;
                    end else if (w_mix < -MIX_LIMIT) begin
                        r_audio   <= 12'(-MIX_LIMIT);
                        r_clipped <= 1'b1;
                    end else begin
                        r_audio   <= w_mix[11:0];
                        r_clipped <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.pending  = r_pending;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_audio        = r_audio;
    assign o_clipped      = r_clipped;

endmodule

// File: rtl/core/adpcm_four_voice_sample_player_core.sv
// top level of the four-voice adpcm sample player
// A ROM load or a stop/latch command byte is taken in the idle state. A start
// command reads the six header bytes through the single registered ROM port.
// An output tick walks the four voices one after another through read,
// decode, interpolate multiply, volume multiply and accumulate, then filters
// and mixes. The next request is taken while a finished sample waits in the
// output register; a second tick holds in its mix step until that sample is
// taken. The user must write phase_step through i_cfg_we/i_cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module adpcm_four_voice_sample_player_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rom_address[16:0], data_byte[24:17], fm_sample[40:25], zero fill
    input  logic [47:0] s_axis_tdata,
    // opcode[1:0], sample_bank[2]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // audio_sample[11:0], zero fill
    output logic [15:0] m_axis_tdata,
    // clipped[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);
    import afvsp_pkg::*;

    t_dp_ctl            w_ctl;
    t_dp_sts            w_sts;
    logic signed [11:0] w_audio;
    logic               w_clipped;

    afvsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser[1:0]),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_ctl      (w_ctl)
    );

    afvsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_opcode      (s_axis_tuser[1:0]),
        .i_bank        (s_axis_tuser[2]),
        .i_rom_address (s_axis_tdata[16:0]),
        .i_data_byte   (s_axis_tdata[24:17]),
        .i_fm_sample   (s_axis_tdata[40:25]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_audio       (w_audio),
        .o_clipped     (w_clipped)
    );

    assign m_axis_tdata = {4'd0, w_audio};
    assign m_axis_tuser = w_clipped;

`ifndef SYNTH
    // a new result only ever comes out of the mix step
    a_result_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_ctl.op == DP_MIX))
        else $error("result appeared without a mix step");

    // clipping flag only with the output at the limit
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ($signed(m_axis_tdata[11:0]) == 12'sd1200 || $signed(m_axis_tdata[11:0]) == -12'sd1200))
        else $error("clip flag without saturated output");

    // output within the saturation range whenever it is valid
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        ($signed(m_axis_tdata[11:0]) <= 12'sd1200 && $signed(m_axis_tdata[11:0]) >= -12'sd1200))
        else $error("output sample out of range");
`endif

endmodule
